>>> src/bsst_pkg.sv
// shared constants, types and helpers for the bounded step subsequence tracker
// no dependencies; used by bsst_ctrl, bsst_datapath and the top level
package bsst_pkg;

   localparam int VALUE_SLOTS = 1024;
   localparam int LENGTH_BITS = 16;

   localparam int VALUE_W = 10;
   localparam int DIST_W  = 10;
   localparam int OUT_W   = 16;

   localparam int IDX_W  = $clog2(VALUE_SLOTS);
   localparam int NODE_W = $clog2(2 * VALUE_SLOTS);
   localparam int R_W    = NODE_W + 1;
   localparam int SPAN_W = ((IDX_W > DIST_W) ? IDX_W : DIST_W) + 1;
   localparam int MEM_DEPTH = 2 ** NODE_W;

   typedef logic [LENGTH_BITS-1:0] length_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QRY_RD,
      ST_QRY_ACC,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic q_read;
      logic q_step;
      logic u_start;
      logic u_write;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic q_done;
      logic at_root;
   } status_type;

   function automatic logic [OUT_W-1:0] out_sat(input length_type x);
      logic [OUT_W+LENGTH_BITS-1:0] wide;
      wide = {{OUT_W{1'b0}}, x};
      if (wide > (OUT_W+LENGTH_BITS)'({OUT_W{1'b1}})) begin
         return {OUT_W{1'b1}};
      end
      return wide[OUT_W-1:0];
   endfunction

endpackage

>>> src/bsst_ctrl.sv
// sequencer for clearing, range query, leaf-to-root update and result handoff
// depends on bsst_pkg
module bsst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsst_pkg::status_type status,
   output bsst_pkg::cmd_type    cmd
);

   bsst_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsst_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bsst_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = bsst_pkg::ST_IDLE;
            end
         end
         bsst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = bsst_pkg::ST_QRY_RD;
            end
         end
         bsst_pkg::ST_QRY_RD: begin
            if (status.q_done) begin
               cmd.u_start = 1'b1;
               state_in    = bsst_pkg::ST_UPD_RD;
            end else begin
               cmd.q_read = 1'b1;
               state_in   = bsst_pkg::ST_QRY_ACC;
            end
         end
         bsst_pkg::ST_QRY_ACC: begin
            cmd.q_step = 1'b1;
            state_in   = bsst_pkg::ST_QRY_RD;
         end
         bsst_pkg::ST_UPD_RD: begin
            state_in = bsst_pkg::ST_UPD_WR;
         end
         bsst_pkg::ST_UPD_WR: begin
            cmd.u_write = 1'b1;
            state_in    = status.at_root ? bsst_pkg::ST_DONE : bsst_pkg::ST_UPD_RD;
         end
         bsst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = bsst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsst_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/bsst_datapath.sv
// max tree memory, query bounds, running maximum and output registers
// depends on bsst_pkg; driven by bsst_ctrl
module bsst_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bsst_pkg::DIST_W-1:0]    csr_wr_data,
   input  logic [bsst_pkg::VALUE_W-1:0]   req_value,
   input  bsst_pkg::cmd_type              cmd,
   output bsst_pkg::status_type           status,
   output logic [bsst_pkg::OUT_W-1:0]     rsp_chain_length,
   output logic [bsst_pkg::OUT_W-1:0]     rsp_best_length
);

   localparam int NW = bsst_pkg::NODE_W;
   localparam int RW = bsst_pkg::R_W;
   localparam int SW = bsst_pkg::SPAN_W;
   localparam int IW = bsst_pkg::IDX_W;

   bsst_pkg::length_type mem [bsst_pkg::MEM_DEPTH];

   logic [bsst_pkg::DIST_W-1:0] dist_ff;
   logic [NW-1:0]               clr_ff;
   logic [IW-1:0]               v_ff;
   logic [RW-1:0]               l_ff, l_in;
   logic [RW-1:0]               r_ff, r_in;
   logic [NW-1:0]               node_ff, node_in;
   bsst_pkg::length_type        m_ff, m_in;
   bsst_pkg::length_type        chain_ff, chain_in;
   bsst_pkg::length_type        best_ff, best_in;
   bsst_pkg::length_type        rd_a_ff, rd_b_ff;
   bsst_pkg::length_type        wr_data;
   logic [bsst_pkg::OUT_W-1:0]  out_chain_ff, out_best_ff;

   logic [SW-1:0] span_value, span_v, span_d, lo, hi_raw, hi;
   logic [IW-1:0] v_clamp;
   logic [RW-1:0] r_last;
   logic [NW-1:0] rd_a_addr, rd_b_addr;
   bsst_pkg::length_type cand_a, cand_b, m_ab;

   // clamp value and bound the query window to the table
   always_comb begin
      span_value = SW'(req_value);
      if (span_value > SW'(bsst_pkg::VALUE_SLOTS - 1)) begin
         v_clamp = IW'(bsst_pkg::VALUE_SLOTS - 1);
      end else begin
         v_clamp = span_value[IW-1:0];
      end
      span_v = SW'(v_clamp);
      span_d = SW'(dist_ff);
      lo     = (span_v > span_d) ? span_v - span_d : '0;
      hi_raw = span_v + span_d;
      hi     = (hi_raw > SW'(bsst_pkg::VALUE_SLOTS - 1)) ?
               SW'(bsst_pkg::VALUE_SLOTS - 1) : hi_raw;
   end

   // bottom-up query step: odd left bound and odd right bound contribute
   always_comb begin
      cand_a = l_ff[0] ? rd_a_ff : '0;
      cand_b = r_ff[0] ? rd_b_ff : '0;
      m_ab   = (cand_a > cand_b) ? cand_a : cand_b;
      r_last = r_ff - RW'(1);
   end

   always_comb begin
      l_in     = l_ff;
      r_in     = r_ff;
      m_in     = m_ff;
      node_in  = node_ff;
      chain_in = chain_ff;
      best_in  = best_ff;
      if (cmd.start) begin
         l_in = RW'(lo) + RW'(bsst_pkg::VALUE_SLOTS);
         r_in = RW'(hi) + RW'(bsst_pkg::VALUE_SLOTS) + RW'(1);
         m_in = '0;
      end
      if (cmd.q_step) begin
         l_in = (l_ff + RW'(l_ff[0])) >> 1;
         r_in = (r_ff - RW'(r_ff[0])) >> 1;
         m_in = (m_ab > m_ff) ? m_ab : m_ff;
      end
      if (cmd.u_start) begin
         chain_in = (m_ff == '1) ? m_ff : m_ff + 1'b1;
         node_in  = NW'(v_ff) + NW'(bsst_pkg::VALUE_SLOTS);
         best_in  = (chain_in > best_ff) ? chain_in : best_ff;
      end
      if (cmd.u_write) begin
         node_in = node_ff >> 1;
      end
   end

   assign rd_a_addr = cmd.q_read ? l_ff[NW-1:0] : node_ff;
   assign rd_b_addr = r_last[NW-1:0];
   assign wr_data   = (rd_a_ff > chain_ff) ? rd_a_ff : chain_ff;

   // tree memory: two read ports, one write port
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.u_write) begin
         mem[node_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
         clr_ff  <= '0;
         best_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            dist_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         v_ff <= v_clamp;
      end
      l_ff     <= l_in;
      r_ff     <= r_in;
      m_ff     <= m_in;
      node_ff  <= node_in;
      chain_ff <= chain_in;
      if (cmd.load_out) begin
         out_chain_ff <= bsst_pkg::out_sat(chain_ff);
         out_best_ff  <= bsst_pkg::out_sat(best_ff);
      end
   end

   assign status.clear_last = (clr_ff == '1);
   assign status.q_done     = (l_ff >= r_ff);
   assign status.at_root    = (node_ff == NW'(1));

   assign rsp_chain_length = out_chain_ff;
   assign rsp_best_length  = out_best_ff;

endmodule

>>> src/bounded_step_subsequence_tracker_unit.sv
// top level of the bounded step subsequence tracker
// depends on bsst_pkg, bsst_ctrl and bsst_datapath
//
// longest subsequence tracker with a bounded step between neighbors. a max
// segment tree indexed by value (2048 nodes, 16-bit lengths, in one memory with
// two read ports) holds the best chain length ending at each value. each
// request transaction looks up the tree maximum over value +/- max_distance
// (clamped to the table), adds one with saturation, raises that value's leaf
// and its ancestors, and returns one response transaction carrying the chain
// length and the running best length. after reset a clearing pass zeroes the
// tree, one node a cycle; req_ready stays low meanwhile, csr writes are taken
// at any time but must only change while idle. one item is worked at a time:
// the query climbs the tree one level per read-then-combine step on the memory
// (1 to 11 levels, more for a wider window), the update walks from leaf to root
// (11 levels, read-modify-write on the single write port), and the accept, the
// end-of-query check and the result load each take a sequencer state of their
// own. a finished result sits in an output register so the next request is
// accepted while the response waits; a result that finds the previous response
// still waiting stalls until it is taken.
module bounded_step_subsequence_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [bsst_pkg::DIST_W-1:0]   csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsst_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsst_pkg::OUT_W-1:0]    rsp_chain_length,
   output logic [bsst_pkg::OUT_W-1:0]    rsp_best_length
);

   // command and status between sequencer and datapath
   bsst_pkg::cmd_type    cmd;
   bsst_pkg::status_type status;

   // sequencer: clear pass, query loop, update walk, response handoff
   bsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: tree memory, window bounds, maximum, output registers
   bsst_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_chain_length (rsp_chain_length),
      .rsp_best_length  (rsp_best_length)
   );

endmodule
